### design/pib_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pib_pkg;

  // Number of palette slots, one cell of the chain per slot.
  localparam int PALETTE_SIZE = 256;

  localparam int IDX_W = (PALETTE_SIZE > 2) ? $clog2(PALETTE_SIZE) : 1;
  localparam int CNT_W = $clog2(PALETTE_SIZE + 1);

  // Widths used to extend before masking down to the result fields.
  localparam int IDX_EXT_W = (IDX_W > 8) ? IDX_W : 8;
  localparam int CNT_EXT_W = (CNT_W > 9) ? CNT_W : 9;

  // One pixel as it travels down the chain of cells.
  typedef struct packed {
    logic             valid;
    logic             soi;
    logic [31:0]      color;
    logic             found;
    logic             added;
    logic [IDX_W-1:0] index;
  } token_t;

endpackage

`default_nettype wire

### design/pib_pixel_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pib_pixel_if;
  logic       valid;
  logic       ready;
  logic       start_of_image;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (
    output valid, start_of_image, red, green, blue, alpha,
    input  ready
  );

  modport sink (
    input  valid, start_of_image, red, green, blue, alpha,
    output ready
  );
endinterface

`default_nettype wire

### design/pib_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pib_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;
  logic       new_color;
  logic       overflow;
  logic [8:0] colors_used;

  modport source (
    output valid, color_index, new_color, overflow, colors_used,
    input  ready
  );

  modport sink (
    input  valid, color_index, new_color, overflow, colors_used,
    output ready
  );
endinterface

`default_nettype wire

### design/pib_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One palette slot. It compares the passing pixel with its entry, or claims
// the pixel's colour when it is the first free slot, then hands the pixel on.
module pib_cell import pib_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [IDX_W-1:0] cell_index,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic        used;
  logic [31:0] entry;
  logic        used_eff;
  logic        used_next;
  logic        store;
  token_t      tok_next;

  always_comb begin
    // A start of image empties this slot before the pixel looks at it.
    used_eff  = used & ~(tok_in.valid & tok_in.soi);
    used_next = used_eff;
    store     = 1'b0;
    tok_next  = tok_in;
    if (tok_in.valid && !tok_in.found) begin
      if (used_eff) begin
        if (entry == tok_in.color) begin
          tok_next.found = 1'b1;
          tok_next.index = cell_index;
        end
      end else begin
        store          = 1'b1;
        used_next      = 1'b1;
        tok_next.found = 1'b1;
        tok_next.added = 1'b1;
        tok_next.index = cell_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      used    <= used_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && store) begin
      entry <= tok_in.color;
    end
  end

endmodule

`default_nettype wire

### design/pib_tail.sv
`timescale 1ns / 1ps
`default_nettype none

// End of the chain: keeps the colour count and the sticky overflow flag and
// holds the result register.
module pib_tail import pib_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  token_t           tok_in,
  output logic             out_valid,
  output logic [7:0]       color_index,
  output logic             new_color,
  output logic             overflow,
  output logic [8:0]       colors_used,
  output logic [CNT_W-1:0] entries
);

  logic             ovf_seen;
  logic [CNT_W-1:0] count_base;
  logic [CNT_W-1:0] count_next;
  logic             ovf_next;
  logic [IDX_W-1:0] index_sel;

  always_comb begin
    count_base = tok_in.soi ? '0 : entries;
    count_next = count_base + CNT_W'(tok_in.added);
    ovf_next   = (ovf_seen & ~tok_in.soi) | ~tok_in.found;
    index_sel  = tok_in.found ? tok_in.index : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries   <= '0;
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tok_in.valid;
      if (tok_in.valid) begin
        entries  <= count_next;
        ovf_seen <= ovf_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok_in.valid) begin
      color_index <= IDX_EXT_W'(index_sel) & IDX_EXT_W'(8'hFF);
      new_color   <= tok_in.added;
      overflow    <= ovf_next;
      colors_used <= 9'(CNT_EXT_W'(count_next));
    end
  end

endmodule

`default_nettype wire

### design/palette_index_builder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Modport   Direction  Contents
// pixel     sink      in         start_of_image, red, green, blue, alpha
// result    source    out        color_index, new_color, overflow, colors_used
//
// Each pixel request enters a systolic row of PALETTE_SIZE cells and moves one
// cell per cycle while the row advances, so a new request is taken every such
// cycle; the length of the cell row sets how long its result takes to leave.
// Reset empties the palette and clears the count and the overflow flag at once.
// A stalled result freezes the whole row, and pixel.ready drops with it.
module palette_index_builder import pib_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pib_pixel_if.sink  pixel,
  pib_result_if.source result
);

  // The whole row moves together whenever the result register is free.
  logic             advance;
  token_t           tok [PALETTE_SIZE+1];
  logic [CNT_W-1:0] entries;

  assign advance     = !result.valid || result.ready;
  assign pixel.ready = advance;

  // Entry register: the packed colour starts with nothing found yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else if (advance) begin
      tok[0].valid <= pixel.valid;
      tok[0].soi   <= pixel.start_of_image;
      tok[0].color <= {pixel.red, pixel.green, pixel.blue, pixel.alpha};
      tok[0].found <= 1'b0;
      tok[0].added <= 1'b0;
      tok[0].index <= '0;
    end
  end

  // Slot k lives in cell k. Filled slots always form a prefix of the row, so
  // the first free cell a missing colour reaches is the next free slot. A
  // pixel right behind another sees every slot that one claimed.
  for (genvar g = 0; g < PALETTE_SIZE; g++) begin : g_cell
    pib_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .cell_index(IDX_W'(g)),
      .tok_in    (tok[g]),
      .tok_out   (tok[g+1])
    );
  end

  // A pixel that leaves the row unmatched found the palette full.
  pib_tail u_tail (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .tok_in     (tok[PALETTE_SIZE]),
    .out_valid  (result.valid),
    .color_index(result.color_index),
    .new_color  (result.new_color),
    .overflow   (result.overflow),
    .colors_used(result.colors_used),
    .entries    (entries)
  );

  // A colour can only be added while the palette still has room.
  a_no_add_after_overflow: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.new_color && result.overflow))
    else $error("new colour reported together with overflow");

  // Overflow is only ever seen with a full palette.
  a_overflow_means_full: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.overflow |-> entries == CNT_W'(PALETTE_SIZE))
    else $error("overflow reported with free palette slots");

  // The count never passes the number of slots.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entries <= CNT_W'(PALETTE_SIZE))
    else $error("palette count exceeds the number of slots");

  // An accepted pixel is in the entry register on the next edge.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.ready |=> tok[0].valid)
    else $error("accepted pixel did not enter the cell row");

endmodule

`default_nettype wire
